>>> rtl/core/assert_macros.svh
// Assertion helpers for the checker modules.
// Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/core/rrlc_pkg.sv
// ----------------------------------------------------------------------------
// rrlc_pkg
// Shared constants for the range registration LRU cache: field widths,
// operation codes, status codes and register indexes.
// ----------------------------------------------------------------------------
package rrlc_pkg;

	localparam int POOL_ENTRIES_DEF  = 64;
	localparam int CACHE_ENTRIES_DEF = 16;

	localparam int ADDR_W     = 48;
	localparam int LEN_W      = 32;
	localparam int HANDLE_W   = 6;
	localparam int RC_W       = 16;
	localparam int CAP_W      = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic [RC_W-1:0] RC_MAX = '1;

	localparam logic [1:0] FN_REG_CACHED   = 2'd0;
	localparam logic [1:0] FN_REG_UNCACHED = 2'd1;
	localparam logic [1:0] FN_UNREG        = 2'd2;
	localparam logic [1:0] FN_NOP          = 2'd3;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_NO_FREE     = 2'd1;
	localparam logic [1:0] ST_BAD_RELEASE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_CACHE_ENABLE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CACHE_CAPACITY = 2'd1;

endpackage

>>> rtl/core/rrlc_range_cmp.sv
// ----------------------------------------------------------------------------
// rrlc_range_cmp
// Shared two-step containment check: does [base, base+len) fit inside a
// cached entry's range. The subtract is registered, the add and compare
// follow in the next cycle.
// ----------------------------------------------------------------------------
module rrlc_range_cmp (
	input  logic                         clk,
	input  logic [rrlc_pkg::ADDR_W-1:0]  base,
	input  logic [rrlc_pkg::LEN_W-1:0]   len,
	input  logic [rrlc_pkg::ADDR_W-1:0]  ent_base,
	input  logic [rrlc_pkg::LEN_W-1:0]   ent_len,
	output logic                         match
);

	localparam int AW = rrlc_pkg::ADDR_W;

	logic [AW:0]                   diff_s1;
	logic [rrlc_pkg::LEN_W-1:0]    len_s1;
	logic [rrlc_pkg::LEN_W-1:0]    ent_len_s1;
	logic [AW:0]                   end_off;

	always_ff @(posedge clk) begin
		diff_s1    <= {1'b0, base} - {1'b0, ent_base};
		len_s1     <= len;
		ent_len_s1 <= ent_len;
	end

	// A borrow means the request starts below the entry.
	assign end_off = {1'b0, diff_s1[AW-1:0]} + (AW+1)'(len_s1);
	assign match   = !diff_s1[AW] && (end_off <= (AW+1)'(ent_len_s1));

endmodule

>>> rtl/core/range_registration_lru_cache_unit.sv
// ----------------------------------------------------------------------------
// range_registration_lru_cache_unit
// Memory-registration cache over a fixed pool of entries with an LRU recency
// list, a LIFO free stack and per-entry reference counts.
// ----------------------------------------------------------------------------
//  channel | signals                                   | handshake
//  in      | func base_address length release_handle   | in_valid / in_stall
//  out     | handle hit now_cached evicted             | out_valid / out_stall
//          | evicted_handle status                     |
//  cfg     | cfg_index cfg_data                        | cfg_valid / cfg_ready
//
// One item at a time. A cached lookup scans the recency list entry by entry
// in the shared range compare, then moves the recency slots one by one on a
// hit or insert.
// No clearing pass after reset: the free stack tracks its low-water mark.
// A finished result waits in the output register while a new beat is taken.
// ----------------------------------------------------------------------------
module range_registration_lru_cache_unit #(
	parameter int POOL_ENTRIES  = rrlc_pkg::POOL_ENTRIES_DEF,
	parameter int CACHE_ENTRIES = rrlc_pkg::CACHE_ENTRIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        func,
	input  logic [rrlc_pkg::ADDR_W-1:0]       base_address,
	input  logic [rrlc_pkg::LEN_W-1:0]        length,
	input  logic [rrlc_pkg::HANDLE_W-1:0]     release_handle,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [rrlc_pkg::HANDLE_W-1:0]     handle,
	output logic                              hit,
	output logic                              now_cached,
	output logic                              evicted,
	output logic [rrlc_pkg::HANDLE_W-1:0]     evicted_handle,
	output logic [1:0]                        status,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rrlc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rrlc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int IDX_W = $clog2(POOL_ENTRIES);
	localparam int REC_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
	localparam int FC_W  = $clog2(POOL_ENTRIES + 1);
	localparam int HW    = rrlc_pkg::HANDLE_W;
	localparam int RCW   = rrlc_pkg::RC_W;

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_DISP      = 4'd1;
	localparam logic [3:0] S_REL       = 4'd2;
	localparam logic [3:0] S_SCAN_REC  = 4'd3;
	localparam logic [3:0] S_SCAN_ENT  = 4'd4;
	localparam logic [3:0] S_SCAN_CMP1 = 4'd5;
	localparam logic [3:0] S_SCAN_CMP2 = 4'd6;
	localparam logic [3:0] S_SHIFT_RD  = 4'd7;
	localparam logic [3:0] S_SHIFT_WR  = 4'd8;
	localparam logic [3:0] S_RC_RD     = 4'd9;
	localparam logic [3:0] S_RC_WR     = 4'd10;
	localparam logic [3:0] S_ALLOC     = 4'd11;
	localparam logic [3:0] S_ALLOC_WR  = 4'd12;
	localparam logic [3:0] S_EV_RD     = 4'd13;
	localparam logic [3:0] S_EV_CHK    = 4'd14;
	localparam logic [3:0] S_FIN       = 4'd15;

	function automatic logic [HW-1:0] to_handle(input logic [IDX_W-1:0] x);
		logic [IDX_W+HW-1:0] w;
		w = (IDX_W+HW)'(x);
		return w[HW-1:0];
	endfunction

	// Control state
	logic [3:0]                      state_q;
	logic                            en_q;
	logic [rrlc_pkg::CAP_W-1:0]      cap_reg_q;
	logic [POOL_ENTRIES-1:0]         in_use_q;
	logic [POOL_ENTRIES-1:0]         cached_q;
	logic [CNT_W-1:0]                cached_count_q;
	logic [FC_W-1:0]                 free_count_q;
	logic [FC_W-1:0]                 low_q;
	logic                            out_valid_q;

	// Item registers
	logic [1:0]                      func_q;
	logic [rrlc_pkg::ADDR_W-1:0]     base_q;
	logic [rrlc_pkg::LEN_W-1:0]      len_q;
	logic [HW-1:0]                   rel_q;
	logic                            use_q;
	logic                            ins_q;
	logic [CNT_W-1:0]                i_q;
	logic [CNT_W-1:0]                j_q;
	logic [IDX_W-1:0]                e_q;
	logic [IDX_W-1:0]                h_q;
	logic [IDX_W-1:0]                mv_h_q;

	// Pending and delivered result
	logic [HW-1:0]                   res_h_q;
	logic                            res_hit_q;
	logic                            res_nc_q;
	logic                            res_ev_q;
	logic [HW-1:0]                   res_evh_q;
	logic [1:0]                      res_st_q;
	logic [HW-1:0]                   out_h_q;
	logic                            out_hit_q;
	logic                            out_nc_q;
	logic                            out_ev_q;
	logic [HW-1:0]                   out_evh_q;
	logic [1:0]                      out_st_q;

	// Memories
	logic [IDX_W-1:0]                rec_mem [CACHE_ENTRIES];
	logic [rrlc_pkg::ADDR_W-1:0]     base_mem [POOL_ENTRIES];
	logic [rrlc_pkg::LEN_W-1:0]      len_mem [POOL_ENTRIES];
	logic [RCW-1:0]                  rc_mem [POOL_ENTRIES];
	logic [IDX_W-1:0]                fs_mem [POOL_ENTRIES];

	logic [REC_W-1:0]                rec_raddr, rec_waddr;
	logic [IDX_W-1:0]                rec_wdata, rec_rdata_q;
	logic                            rec_we;
	logic [rrlc_pkg::ADDR_W-1:0]     ent_rbase_q;
	logic [rrlc_pkg::LEN_W-1:0]      ent_rlen_q;
	logic                            ent_we;
	logic [IDX_W-1:0]                rc_raddr, rc_waddr;
	logic [RCW-1:0]                  rc_wdata, rc_rdata_q;
	logic                            rc_we;
	logic [IDX_W-1:0]                fs_waddr, fs_wdata, fs_rdata_q;
	logic                            fs_we;

	// Derived values
	logic [IDX_W+HW-1:0]             rel_w;
	logic [IDX_W-1:0]                rel_idx;
	logic                            rel_ok;
	logic [FC_W-1:0]                 pos;
	logic                            pos_init;
	logic [IDX_W-1:0]                h_new;
	logic [CNT_W-1:0]                cap;
	logic [CNT_W-1:0]                jm1;
	logic [CNT_W-1:0]                cm1;
	logic                            fs_room;
	logic                            match;
	logic                            out_load;

	assign rel_w    = (IDX_W+HW)'(rel_q);
	assign rel_idx  = rel_w[IDX_W-1:0];
	assign rel_ok   = (32'(rel_q) < POOL_ENTRIES) && in_use_q[rel_idx];
	assign pos      = free_count_q - FC_W'(1);
	// Stack slots below the low-water mark were never written since reset.
	assign pos_init = pos < low_q;
	assign h_new    = pos_init ? (IDX_W'(POOL_ENTRIES - 1) - pos[IDX_W-1:0]) : fs_rdata_q;
	assign cap      = (32'(cap_reg_q) < CACHE_ENTRIES) ? CNT_W'(cap_reg_q)
	                                                   : CNT_W'(CACHE_ENTRIES);
	assign jm1      = j_q - CNT_W'(1);
	assign cm1      = cached_count_q - CNT_W'(1);
	assign fs_room  = free_count_q < FC_W'(POOL_ENTRIES);
	assign out_load = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	assign in_stall       = (state_q != S_IDLE);
	assign cfg_ready      = 1'b1;
	assign out_valid      = out_valid_q;
	assign handle         = out_h_q;
	assign hit            = out_hit_q;
	assign now_cached     = out_nc_q;
	assign evicted        = out_ev_q;
	assign evicted_handle = out_evh_q;
	assign status         = out_st_q;

	rrlc_range_cmp u_cmp (
		.clk      (clk),
		.base     (base_q),
		.len      (len_q),
		.ent_base (ent_rbase_q),
		.ent_len  (ent_rlen_q),
		.match    (match)
	);

	// Memory port control
	always_comb begin
		rec_raddr = i_q[REC_W-1:0];
		rec_waddr = j_q[REC_W-1:0];
		rec_wdata = rec_rdata_q;
		rec_we    = 1'b0;
		ent_we    = 1'b0;
		rc_raddr  = e_q;
		rc_waddr  = e_q;
		rc_wdata  = '0;
		rc_we     = 1'b0;
		fs_waddr  = free_count_q[IDX_W-1:0];
		fs_wdata  = e_q;
		fs_we     = 1'b0;
		case (state_q)
			S_DISP: begin
				rc_raddr = rel_idx;
			end
			S_REL: begin
				rc_waddr = rel_idx;
				fs_wdata = rel_idx;
				if (cached_q[rel_idx]) begin
					rc_we    = (rc_rdata_q != '0);
					rc_wdata = rc_rdata_q - RCW'(1);
				end else begin
					fs_we = fs_room;
				end
			end
			S_SHIFT_RD: begin
				rec_raddr = jm1[REC_W-1:0];
				if (j_q == '0) begin
					rec_we    = 1'b1;
					rec_waddr = '0;
					rec_wdata = mv_h_q;
					rc_we     = ins_q;
					rc_waddr  = mv_h_q;
					rc_wdata  = RCW'(1);
				end
			end
			S_SHIFT_WR: begin
				rec_we = 1'b1;
			end
			S_RC_WR: begin
				rc_we    = 1'b1;
				rc_wdata = (rc_rdata_q == rrlc_pkg::RC_MAX) ? rc_rdata_q
				                                             : rc_rdata_q + RCW'(1);
			end
			S_ALLOC_WR: begin
				rec_raddr = cm1[REC_W-1:0];
				ent_we    = 1'b1;
				rc_we     = 1'b1;
				rc_waddr  = h_new;
			end
			S_EV_RD: begin
				rc_raddr = rec_rdata_q;
			end
			S_EV_CHK: begin
				fs_we = (rc_rdata_q == '0) && fs_room;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rec_we) begin
			rec_mem[rec_waddr] <= rec_wdata;
		end
		rec_rdata_q <= rec_mem[rec_raddr];
	end

	always_ff @(posedge clk) begin
		if (ent_we) begin
			base_mem[h_new] <= base_q;
			len_mem[h_new]  <= len_q;
		end
		ent_rbase_q <= base_mem[rec_rdata_q];
		ent_rlen_q  <= len_mem[rec_rdata_q];
	end

	always_ff @(posedge clk) begin
		if (rc_we) begin
			rc_mem[rc_waddr] <= rc_wdata;
		end
		rc_rdata_q <= rc_mem[rc_raddr];
	end

	always_ff @(posedge clk) begin
		if (fs_we) begin
			fs_mem[fs_waddr] <= fs_wdata;
		end
		fs_rdata_q <= fs_mem[pos[IDX_W-1:0]];
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q      <= 1'b1;
			cap_reg_q <= rrlc_pkg::CAP_W'(16);
		end else if (cfg_valid) begin
			case (cfg_index)
				rrlc_pkg::REG_CACHE_ENABLE:   en_q      <= cfg_data[0];
				rrlc_pkg::REG_CACHE_CAPACITY: cap_reg_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_h_q   <= res_h_q;
			out_hit_q <= res_hit_q;
			out_nc_q  <= res_nc_q;
			out_ev_q  <= res_ev_q;
			out_evh_q <= res_evh_q;
			out_st_q  <= res_st_q;
		end
	end

	// Item payload and scratch registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				func_q <= func;
				base_q <= base_address;
				len_q  <= length;
				rel_q  <= release_handle;
			end
			S_DISP: begin
				res_h_q   <= '0;
				res_hit_q <= 1'b0;
				res_nc_q  <= 1'b0;
				res_ev_q  <= 1'b0;
				res_evh_q <= '0;
				res_st_q  <= rrlc_pkg::ST_OK;
				use_q     <= (func_q == rrlc_pkg::FN_REG_CACHED) && en_q;
				i_q       <= '0;
				if (func_q == rrlc_pkg::FN_UNREG) begin
					res_h_q <= rel_q;
					if (!rel_ok) begin
						res_st_q <= rrlc_pkg::ST_BAD_RELEASE;
					end
				end
			end
			S_REL: begin
				res_nc_q <= cached_q[rel_idx];
			end
			S_SCAN_ENT: begin
				e_q <= rec_rdata_q;
			end
			S_SCAN_CMP2: begin
				if (match) begin
					j_q    <= i_q;
					mv_h_q <= e_q;
					ins_q  <= 1'b0;
				end else begin
					i_q <= i_q + CNT_W'(1);
				end
			end
			S_SHIFT_RD: begin
				if (j_q == '0 && ins_q) begin
					res_h_q  <= to_handle(mv_h_q);
					res_nc_q <= 1'b1;
				end
			end
			S_SHIFT_WR: begin
				j_q <= jm1;
			end
			S_RC_WR: begin
				res_h_q   <= to_handle(e_q);
				res_hit_q <= 1'b1;
				res_nc_q  <= 1'b1;
			end
			S_ALLOC: begin
				if (free_count_q == '0) begin
					res_st_q <= rrlc_pkg::ST_NO_FREE;
				end
			end
			S_ALLOC_WR: begin
				h_q     <= h_new;
				res_h_q <= to_handle(h_new);
				mv_h_q  <= h_new;
				j_q     <= cached_count_q;
				ins_q   <= 1'b1;
			end
			S_EV_RD: begin
				e_q <= rec_rdata_q;
			end
			S_EV_CHK: begin
				if (rc_rdata_q == '0) begin
					res_ev_q  <= 1'b1;
					res_evh_q <= to_handle(e_q);
					mv_h_q    <= h_q;
					j_q       <= cm1;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer and entry bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			in_use_q       <= '0;
			cached_q       <= '0;
			cached_count_q <= '0;
			free_count_q   <= FC_W'(POOL_ENTRIES);
			low_q          <= FC_W'(POOL_ENTRIES);
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					case (func_q)
						rrlc_pkg::FN_NOP: state_q <= S_FIN;
						rrlc_pkg::FN_UNREG: state_q <= rel_ok ? S_REL : S_FIN;
						default: begin
							if (func_q == rrlc_pkg::FN_REG_CACHED && en_q &&
							    cached_count_q != '0) begin
								state_q <= S_SCAN_REC;
							end else begin
								state_q <= S_ALLOC;
							end
						end
					endcase
				end
				S_REL: begin
					if (!cached_q[rel_idx]) begin
						in_use_q[rel_idx] <= 1'b0;
						if (fs_room) begin
							free_count_q <= free_count_q + FC_W'(1);
						end
					end
					state_q <= S_FIN;
				end
				S_SCAN_REC:  state_q <= S_SCAN_ENT;
				S_SCAN_ENT:  state_q <= S_SCAN_CMP1;
				S_SCAN_CMP1: state_q <= S_SCAN_CMP2;
				S_SCAN_CMP2: begin
					if (match) begin
						state_q <= S_SHIFT_RD;
					end else if ((i_q + CNT_W'(1)) < cached_count_q) begin
						state_q <= S_SCAN_REC;
					end else begin
						state_q <= S_ALLOC;
					end
				end
				S_SHIFT_RD: begin
					if (j_q != '0) begin
						state_q <= S_SHIFT_WR;
					end else if (ins_q) begin
						cached_q[mv_h_q] <= 1'b1;
						cached_count_q   <= cached_count_q + CNT_W'(1);
						state_q          <= S_FIN;
					end else begin
						state_q <= S_RC_RD;
					end
				end
				S_SHIFT_WR: state_q <= S_SHIFT_RD;
				S_RC_RD:    state_q <= S_RC_WR;
				S_RC_WR:    state_q <= S_FIN;
				S_ALLOC: begin
					state_q <= (free_count_q == '0) ? S_FIN : S_ALLOC_WR;
				end
				S_ALLOC_WR: begin
					in_use_q[h_new] <= 1'b1;
					cached_q[h_new] <= 1'b0;
					free_count_q    <= pos;
					if (pos_init) begin
						low_q <= pos;
					end
					if (!use_q || cap == '0) begin
						state_q <= S_FIN;
					end else if (cached_count_q >= cap) begin
						state_q <= S_EV_RD;
					end else begin
						state_q <= S_SHIFT_RD;
					end
				end
				S_EV_RD: state_q <= S_EV_CHK;
				S_EV_CHK: begin
					if (rc_rdata_q != '0) begin
						state_q <= S_FIN;
					end else begin
						cached_count_q <= cm1;
						in_use_q[e_q]  <= 1'b0;
						cached_q[e_q]  <= 1'b0;
						if (fs_room) begin
							free_count_q <= free_count_q + FC_W'(1);
						end
						state_q <= (cm1 >= cap) ? S_FIN : S_SHIFT_RD;
					end
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/core/rrlc_checker.sv
// ----------------------------------------------------------------------------
// rrlc_checker
// Port-level checks for the range registration LRU cache, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrlc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [rrlc_pkg::HANDLE_W-1:0] handle,
	input logic                          hit,
	input logic                          now_cached,
	input logic                          evicted,
	input logic [rrlc_pkg::HANDLE_W-1:0] evicted_handle,
	input logic [1:0]                    status
);

	// The block works on one beat at a time.
	`ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

	// A hit reuses an entry: it stays cached and nothing is evicted.
	`ASSERT_SAME(a_hit_shape, out_valid && hit, now_cached && !evicted && status == rrlc_pkg::ST_OK)

	// An empty pool reports nothing but the status.
	`ASSERT_SAME(a_no_free_shape, out_valid && status == rrlc_pkg::ST_NO_FREE, handle == '0 && !hit && !now_cached && !evicted)

	`ASSERT_SAME(a_evh_zero, out_valid && !evicted, evicted_handle == '0)

	`ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(handle) && $stable(status))

endmodule

bind range_registration_lru_cache_unit rrlc_checker u_rrlc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.handle         (handle),
	.hit            (hit),
	.now_cached     (now_cached),
	.evicted        (evicted),
	.evicted_handle (evicted_handle),
	.status         (status)
);

>>> sim/tb_range_registration_lru_cache_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_range_registration_lru_cache_unit
// Drives registration, unregistration and no-op requests into the cache with
// random sender gaps and receiver stalls, and checks each result beat against
// a behavioral copy of the pool, the recency list and the free stack kept in a
// scoreboard class. Both configuration registers are swept between phases.
// ----------------------------------------------------------------------------
module tb_range_registration_lru_cache_unit;

	localparam int POOL  = 64;
	localparam int CACHE = 16;

	typedef struct packed {
		logic [rrlc_pkg::HANDLE_W-1:0] handle;
		logic                          hit;
		logic                          now_cached;
		logic                          evicted;
		logic [rrlc_pkg::HANDLE_W-1:0] evicted_handle;
		logic [1:0]                    status;
	} grant_t;

	int errors = 0;

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	class regcache_scoreboard;
		logic [rrlc_pkg::ADDR_W-1:0] base_q[POOL];
		logic [rrlc_pkg::LEN_W-1:0]  len_q[POOL];
		int unsigned         refs[POOL];
		bit                  in_use[POOL];
		bit                  cached[POOL];
		int unsigned         recency[CACHE];
		int unsigned         n_cached;
		int unsigned         free_stk[POOL];
		int unsigned         n_free;
		bit                  enable;
		int unsigned         capacity;
		grant_t              pending[$];

		function void init();
			for (int i = 0; i < POOL; i++) begin
				refs[i] = 0; in_use[i] = 0; cached[i] = 0;
				free_stk[i] = POOL - 1 - i;
			end
			n_cached = 0; n_free = POOL; enable = 1; capacity = 16;
		endfunction

		function void release_entry(int unsigned h);
			in_use[h] = 0; cached[h] = 0; refs[h] = 0;
			if (n_free < POOL) begin
				free_stk[n_free] = h;
				n_free++;
			end
		endfunction

		function void to_front(int unsigned pos, int unsigned h);
			for (int i = pos; i > 0; i--) recency[i] = recency[i-1];
			recency[0] = h;
		endfunction

		function grant_t predict(logic [1:0] fn, logic [rrlc_pkg::ADDR_W-1:0] b,
			logic [rrlc_pkg::LEN_W-1:0] l, logic [rrlc_pkg::HANDLE_W-1:0] rel);
			grant_t g;
			bit uc;
			int unsigned h, cap, e;
			logic [rrlc_pkg::ADDR_W:0] span;
			g = '0;
			if (fn == rrlc_pkg::FN_NOP) return g;
			if (fn == rrlc_pkg::FN_UNREG) begin
				g.handle = rel;
				if (!in_use[rel]) begin
					g.status = rrlc_pkg::ST_BAD_RELEASE;
					return g;
				end
				if (cached[rel]) begin
					if (refs[rel] > 0) refs[rel]--;
					g.now_cached = 1;
				end else begin
					release_entry(rel);
				end
				return g;
			end
			uc = (fn == rrlc_pkg::FN_REG_CACHED) && enable;
			if (uc) begin
				for (int i = 0; i < n_cached; i++) begin
					e = recency[i];
					span = {1'b0, b - base_q[e]} + l;
					if (b >= base_q[e] && span <= len_q[e]) begin
						to_front(i, e);
						if (refs[e] < 65535) refs[e]++;
						g.handle = e; g.hit = 1; g.now_cached = 1;
						return g;
					end
				end
			end
			if (n_free == 0) begin
				g.status = rrlc_pkg::ST_NO_FREE;
				return g;
			end
			n_free--;
			h = free_stk[n_free];
			in_use[h] = 1; cached[h] = 0; refs[h] = 0;
			base_q[h] = b; len_q[h] = l;
			g.handle = h;
			if (!uc) return g;
			cap = capacity < CACHE ? capacity : CACHE;
			if (cap == 0) return g;
			if (n_cached >= cap) begin
				e = recency[n_cached-1];
				if (refs[e] > 0) return g;
				n_cached--;
				release_entry(e);
				g.evicted = 1; g.evicted_handle = e;
				if (n_cached >= cap) return g;
			end
			to_front(n_cached, h);
			n_cached++;
			cached[h] = 1; refs[h] = 1;
			g.now_cached = 1;
			return g;
		endfunction

		function void note_request(logic [1:0] fn, logic [rrlc_pkg::ADDR_W-1:0] b,
			logic [rrlc_pkg::LEN_W-1:0] l, logic [rrlc_pkg::HANDLE_W-1:0] rel);
			pending.push_back(predict(fn, b, l, rel));
		endfunction

		task check_grant(grant_t got);
			grant_t w;
			if (pending.size() == 0) begin
				report_mismatch("unexpected beat", got, 0);
				return;
			end
			w = pending.pop_front();
			if (got.handle != w.handle) report_mismatch("handle", got.handle, w.handle);
			if (got.hit != w.hit) report_mismatch("hit", got.hit, w.hit);
			if (got.now_cached != w.now_cached)
				report_mismatch("now_cached", got.now_cached, w.now_cached);
			if (got.evicted != w.evicted) report_mismatch("evicted", got.evicted, w.evicted);
			if (got.evicted_handle != w.evicted_handle)
				report_mismatch("evicted_handle", got.evicted_handle, w.evicted_handle);
			if (got.status != w.status) report_mismatch("status", got.status, w.status);
		endtask
	endclass

	logic                          clk = 0;
	logic                          arst_n = 0;
	logic                          in_valid = 0;
	logic                          in_stall;
	logic [1:0]                    func = '0;
	logic [rrlc_pkg::ADDR_W-1:0]   base_address = '0;
	logic [rrlc_pkg::LEN_W-1:0]    length = '0;
	logic [rrlc_pkg::HANDLE_W-1:0] release_handle = '0;
	logic                          out_valid;
	logic                          out_stall = 0;
	logic [rrlc_pkg::HANDLE_W-1:0] handle;
	logic                          hit, now_cached, evicted;
	logic [rrlc_pkg::HANDLE_W-1:0] evicted_handle;
	logic [1:0]                    status;
	logic                          cfg_valid = 0;
	logic                          cfg_ready;
	logic [rrlc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [rrlc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	regcache_scoreboard sb = new();
	int stall_mode = 0;
	int burst_left = 0;

	range_registration_lru_cache_unit u_dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Result side: check on the rising edge, pick the next stall at the falling.
	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_grant({handle, hit, now_cached, evicted, evicted_handle, status});

	always @(negedge clk) begin
		case (stall_mode)
			0: out_stall <= 0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 9) < 7);
		endcase
		if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
	end

	task automatic write_reg(input logic [rrlc_pkg::CFG_IDX_W-1:0] idx, input int val);
		@(negedge clk);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= rrlc_pkg::CFG_DATA_W'(val);
		do @(posedge clk); while (!cfg_ready);
		if (idx == rrlc_pkg::REG_CACHE_ENABLE) sb.enable = val[0];
		else sb.capacity = val[4:0];
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic send(input logic [1:0] fn, input logic [rrlc_pkg::ADDR_W-1:0] b,
		input logic [rrlc_pkg::LEN_W-1:0] l, input logic [rrlc_pkg::HANDLE_W-1:0] rel);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		in_valid <= 1; func <= fn; base_address <= b; length <= l;
		release_handle <= rel;
		do @(posedge clk); while (in_stall);
		sb.note_request(fn, b, l, rel);
		burst_left--;
		if (burst_left == 0) begin
			@(negedge clk);
			in_valid <= 0;
		end
	endtask

	task automatic idle_input();
		@(negedge clk);
		in_valid <= 0;
		burst_left = 0;
	endtask

	// Small address windows so lookups hit; occasional fully random fields.
	task automatic random_item();
		logic [rrlc_pkg::ADDR_W-1:0] b;
		logic [rrlc_pkg::LEN_W-1:0] l;
		int r;
		r = $urandom_range(0, 99);
		b = rrlc_pkg::ADDR_W'({$urandom, $urandom});
		l = $urandom;
		if (r < 85) begin
			b = 48'h1000 * $urandom_range(0, 24) + $urandom_range(0, 64);
			l = $urandom_range(0, 4096);
		end
		r = $urandom_range(0, 99);
		if (r < 45) send(rrlc_pkg::FN_REG_CACHED, b, l, rrlc_pkg::HANDLE_W'($urandom));
		else if (r < 60) send(rrlc_pkg::FN_REG_UNCACHED, b, l, rrlc_pkg::HANDLE_W'($urandom));
		else if (r < 97) send(rrlc_pkg::FN_UNREG, b, l, rrlc_pkg::HANDLE_W'($urandom));
		else send(rrlc_pkg::FN_NOP, b, l, rrlc_pkg::HANDLE_W'($urandom));
	endtask

	initial begin
		int caps[6] = '{16, 1, 0, 4, 31, 2};
		sb.init();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// Directed: field extremes, hits, no-op, bad releases.
		send(rrlc_pkg::FN_REG_CACHED, 48'h0, 32'hFFFF_FFFF, 6'd0);
		send(rrlc_pkg::FN_REG_CACHED, 48'h10, 32'h10, 6'd63);
		send(rrlc_pkg::FN_REG_CACHED, 48'hFFFF_FFFF_FFFF, 32'h0, 6'd0);
		send(rrlc_pkg::FN_REG_CACHED, 48'hFFFF_FFFF_FFFF, 32'h1, 6'd0);
		send(rrlc_pkg::FN_REG_UNCACHED, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 6'd0);
		send(rrlc_pkg::FN_UNREG, 48'h0, 32'h0, 6'd63);
		send(rrlc_pkg::FN_UNREG, 48'h0, 32'h0, 6'd3);
		send(rrlc_pkg::FN_UNREG, 48'h0, 32'h0, 6'd3);
		send(rrlc_pkg::FN_UNREG, 48'h0, 32'h0, 6'd0);
		send(rrlc_pkg::FN_UNREG, 48'h0, 32'h0, 6'd0);
		send(rrlc_pkg::FN_NOP, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
		// Exhaust the pool to reach the no-free-entry status.
		for (int i = 0; i < 66; i++)
			send(rrlc_pkg::FN_REG_UNCACHED, rrlc_pkg::ADDR_W'(i), 32'h8, 6'd0);
		send(rrlc_pkg::FN_REG_CACHED, 48'h7777_0000, 32'h8, 6'd0);
		for (int i = 0; i < 64; i++)
			send(rrlc_pkg::FN_UNREG, '0, '0, rrlc_pkg::HANDLE_W'(i));
		idle_input();
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(rrlc_pkg::REG_CACHE_CAPACITY, caps[ph]);
			write_reg(rrlc_pkg::REG_CACHE_ENABLE, (ph == 4) ? 0 : 1);
			for (int n = 0; n < 260; n++) begin
				random_item();
				// Let every result come back once mid-phase.
				if (n == 130) begin
					idle_input();
					while (sb.pending.size() != 0) @(posedge clk);
				end
			end
			// Clean up entries so the pool does not stay exhausted.
			for (int h = 0; h < 64; h++)
				if ($urandom_range(0, 1))
					send(rrlc_pkg::FN_UNREG, '0, '0, rrlc_pkg::HANDLE_W'(h));
			idle_input();
			drain();
		end
		write_reg(rrlc_pkg::REG_CACHE_ENABLE, 1);
		write_reg(rrlc_pkg::REG_CACHE_CAPACITY, 16);

		if (errors == 0 && sb.pending.size() == 0)
			$display("** range_registration_lru_cache_unit: PASSED **");
		else
			$display("** range_registration_lru_cache_unit: FAILED **");
		$finish;
	end

	initial begin
		#40ms;
		$display("** range_registration_lru_cache_unit: FAILED **");
		$finish;
	end
endmodule

>>> files.f
+incdir+rtl/core
rtl/core/rrlc_pkg.sv
rtl/core/rrlc_range_cmp.sv
rtl/core/range_registration_lru_cache_unit.sv
rtl/core/rrlc_checker.sv
sim/tb_range_registration_lru_cache_unit.sv
